// ----- rtl/core/pps_pkg.sv -----
// Package for the preemptive priority scheduler.
// Holds widths, defaults, command codes, the controller state type and the
// command/status structs shared by pps_ctrl, pps_datapath and the top level.
package pps_pkg;

    localparam int MAX_JOBS_DEF    = 16;
    localparam int JOB_COUNT_W     = 5;
    localparam int TIME_W          = 16;
    localparam int PRI_W           = 8;
    localparam int SLOT_IN_W       = 4;

    localparam logic [JOB_COUNT_W-1:0] JOB_COUNT_RESET = 5'd1;
    localparam logic [TIME_W-1:0]      TIME_MAX        = 16'hFFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_RESULT
    } pps_state_t;

    typedef struct packed {
        logic capture;
        logic load_write;
        logic scan_step;
        logic fetch;
        logic update;
        logic commit;
    } pps_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_done;
        logic found;
        logic out_busy;
    } pps_status_t;

endpackage

// ----- rtl/core/pps_ctrl.sv -----
// Controller state machine for the preemptive priority scheduler.
// Sequences load, table scan, job update and result hand-off.
// Depends on pps_pkg for the state type and the command/status structs.
module pps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pps_pkg::pps_status_t status,
    output pps_pkg::pps_cmd_t    cmd
);

    pps_pkg::pps_state_t state_reg;
    pps_pkg::pps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pps_pkg::ST_LOAD;
                end
            end
            pps_pkg::ST_LOAD:
            begin
                state_next = pps_pkg::ST_SCAN;
            end
            pps_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.is_tick && status.found)
                    begin
                        state_next = pps_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = pps_pkg::ST_RESULT;
                    end
                end
            end
            pps_pkg::ST_FETCH:
            begin
                state_next = pps_pkg::ST_UPDATE;
            end
            pps_pkg::ST_UPDATE:
            begin
                state_next = pps_pkg::ST_RESULT;
            end
            pps_pkg::ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            pps_pkg::ST_LOAD:
            begin
                cmd.load_write = 1'b1;
            end
            pps_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            pps_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            pps_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            pps_pkg::ST_RESULT:
            begin
                cmd.commit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/pps_datapath.sv -----
// Datapath of the preemptive priority scheduler: job tables, finished flags,
// scan pipeline, time keeping and the output register.
// Depends on pps_pkg; driven by pps_ctrl through pps_cmd_t.
module pps_datapath #(
    parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pps_pkg::pps_cmd_t                 cmd,
    output pps_pkg::pps_status_t              status,
    input  logic                              cfg_write_en,
    input  logic [pps_pkg::JOB_COUNT_W-1:0]   cfg_write_data,
    input  logic                              command,
    input  logic [pps_pkg::SLOT_IN_W-1:0]     entry_index,
    input  logic [pps_pkg::TIME_W-1:0]        entry_arrival,
    input  logic [pps_pkg::TIME_W-1:0]        entry_burst,
    input  logic [pps_pkg::PRI_W-1:0]         entry_priority,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pps_pkg::SLOT_IN_W-1:0]     running_index,
    output logic                              cpu_idle,
    output logic                              new_segment,
    output logic                              job_finished,
    output logic [pps_pkg::TIME_W-1:0]        turnaround,
    output logic [pps_pkg::TIME_W-1:0]        waiting,
    output logic                              all_done,
    output logic [pps_pkg::TIME_W-1:0]        time_now
);

    localparam int TW     = pps_pkg::TIME_W;
    localparam int PW     = pps_pkg::PRI_W;
    localparam int JW     = pps_pkg::JOB_COUNT_W;
    localparam int SW     = pps_pkg::SLOT_IN_W;
    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int RUN_W  = (IDX_W > SW) ? IDX_W : SW;
    localparam int SLOT_W = RUN_W + 1;
    localparam int CMP_W  = (CNT_W > JW) ? CNT_W : JW;

    // Job tables
    logic [TW-1:0] arrival_mem   [MAX_JOBS];
    logic [TW-1:0] burst_mem     [MAX_JOBS];
    logic [TW-1:0] remaining_mem [MAX_JOBS];
    logic [PW-1:0] priority_mem  [MAX_JOBS];

    logic [TW-1:0] arr_rd_reg;
    logic [TW-1:0] bur_rd_reg;
    logic [TW-1:0] rem_rd_reg;
    logic [PW-1:0] pri_rd_reg;

    // Captured item
    logic          item_tick_reg,  item_tick_next;
    logic [SW-1:0] item_slot_reg,  item_slot_next;
    logic [TW-1:0] item_arr_reg,   item_arr_next;
    logic [TW-1:0] item_bur_reg,   item_bur_next;
    logic [PW-1:0] item_pri_reg,   item_pri_next;

    logic [JW-1:0]       job_count_reg,  job_count_next;
    logic [TW-1:0]       time_reg,       time_next;
    logic [IDX_W-1:0]    last_job_reg,   last_job_next;
    logic                last_valid_reg, last_valid_next;
    logic [MAX_JOBS-1:0] fin_flags_reg,  fin_flags_next;

    // Scan pipeline
    logic [CNT_W-1:0] scan_cnt_reg,  scan_cnt_next;
    logic             p_valid_reg,   p_valid_next;
    logic             p_flag_reg,    p_flag_next;
    logic [IDX_W-1:0] p_idx_reg,     p_idx_next;
    logic [CNT_W-1:0] unfin_reg,     unfin_next;
    logic             found_reg,     found_next;
    logic [IDX_W-1:0] best_idx_reg,  best_idx_next;
    logic [PW-1:0]    best_pri_reg,  best_pri_next;
    logic             fin_reg,       fin_next;
    logic [TW-1:0]    t_reg,         t_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] out_run_reg,   out_run_next;
    logic          out_idle_reg,  out_idle_next;
    logic          out_seg_reg,   out_seg_next;
    logic          out_fin_reg,   out_fin_next;
    logic [TW-1:0] out_tat_reg,   out_tat_next;
    logic [TW-1:0] out_wt_reg,    out_wt_next;
    logic          out_done_reg,  out_done_next;
    logic [TW-1:0] out_time_reg,  out_time_next;

    logic [CNT_W-1:0]  n_active;
    logic [IDX_W-1:0]  scan_addr;
    logic              issue;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [SLOT_W-1:0] slot_wide;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_addr;
    logic              we_load;
    logic              we_upd;
    logic [IDX_W-1:0]  wr_addr;
    logic [TW-1:0]     rem_dec;
    logic [TW-1:0]     rem_wr_data;
    logic [TW-1:0]     time_inc;
    logic              candidate;
    logic [TW-1:0]     w_val;
    logic [RUN_W-1:0]  run_wide;

    always_comb
    begin
        if (CMP_W'(job_count_reg) > CMP_W'(MAX_JOBS))
        begin
            n_active = CNT_W'(MAX_JOBS);
        end
        else
        begin
            n_active = CNT_W'(job_count_reg);
        end
    end

    assign scan_addr = scan_cnt_reg[IDX_W-1:0];
    assign issue     = cmd.scan_step && (scan_cnt_reg < n_active);
    assign rd_addr   = cmd.fetch ? best_idx_reg : scan_addr;
    assign rd_en     = issue || cmd.fetch;

    assign slot_wide = SLOT_W'(item_slot_reg);
    assign slot_ok   = slot_wide < SLOT_W'(MAX_JOBS);
    assign slot_addr = slot_wide[IDX_W-1:0];

    assign we_load     = cmd.load_write && !item_tick_reg && slot_ok;
    assign we_upd      = cmd.update;
    assign wr_addr     = we_upd ? best_idx_reg : slot_addr;
    assign rem_dec     = (rem_rd_reg == '0) ? '0 : rem_rd_reg - TW'(1);
    assign rem_wr_data = we_upd ? rem_dec : item_bur_reg;
    assign time_inc    = (time_reg == pps_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);

    assign candidate = p_valid_reg && item_tick_reg && !p_flag_reg
                       && (arr_rd_reg <= time_reg);
    assign w_val     = (t_reg >= bur_rd_reg) ? t_reg - bur_rd_reg : '0;
    assign run_wide  = RUN_W'(best_idx_reg);

    always_ff @(posedge clk)
    begin
        if (we_load)
        begin
            arrival_mem[wr_addr]  <= item_arr_reg;
            burst_mem[wr_addr]    <= item_bur_reg;
            priority_mem[wr_addr] <= item_pri_reg;
        end
        if (we_load || we_upd)
        begin
            remaining_mem[wr_addr] <= rem_wr_data;
        end
        if (rd_en)
        begin
            arr_rd_reg <= arrival_mem[rd_addr];
            bur_rd_reg <= burst_mem[rd_addr];
            rem_rd_reg <= remaining_mem[rd_addr];
            pri_rd_reg <= priority_mem[rd_addr];
        end
    end

    always_comb
    begin
        item_tick_next  = item_tick_reg;
        item_slot_next  = item_slot_reg;
        item_arr_next   = item_arr_reg;
        item_bur_next   = item_bur_reg;
        item_pri_next   = item_pri_reg;
        job_count_next  = job_count_reg;
        time_next       = time_reg;
        last_job_next   = last_job_reg;
        last_valid_next = last_valid_reg;
        fin_flags_next  = fin_flags_reg;
        scan_cnt_next   = scan_cnt_reg;
        p_valid_next    = p_valid_reg;
        p_flag_next     = p_flag_reg;
        p_idx_next      = p_idx_reg;
        unfin_next      = unfin_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        fin_next        = fin_reg;
        t_next          = t_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_run_next    = out_run_reg;
        out_idle_next   = out_idle_reg;
        out_seg_next    = out_seg_reg;
        out_fin_next    = out_fin_reg;
        out_tat_next    = out_tat_reg;
        out_wt_next     = out_wt_reg;
        out_done_next   = out_done_reg;
        out_time_next   = out_time_reg;

        if (cfg_write_en)
        begin
            job_count_next = cfg_write_data;
        end

        if (cmd.capture)
        begin
            item_tick_next = (command == pps_pkg::CMD_TICK);
            item_slot_next = entry_index;
            item_arr_next  = entry_arrival;
            item_bur_next  = entry_burst;
            item_pri_next  = entry_priority;
            scan_cnt_next  = '0;
            p_valid_next   = 1'b0;
            unfin_next     = '0;
            found_next     = 1'b0;
            fin_next       = 1'b0;
        end

        if (we_load)
        begin
            fin_flags_next[slot_addr] = (item_bur_reg == '0);
        end

        if (cmd.scan_step)
        begin
            p_valid_next = issue;
            p_idx_next   = scan_addr;
            p_flag_next  = fin_flags_reg[scan_addr];
            if (issue)
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            if (p_valid_reg && !p_flag_reg)
            begin
                unfin_next = unfin_reg + CNT_W'(1);
            end
            // strict compare keeps the lowest index on a priority tie
            if (candidate && (!found_reg || (pri_rd_reg < best_pri_reg)))
            begin
                found_next    = 1'b1;
                best_idx_next = p_idx_reg;
                best_pri_next = pri_rd_reg;
            end
        end

        if (cmd.update)
        begin
            time_next = time_inc;
            if (rem_dec == '0)
            begin
                fin_flags_next[best_idx_reg] = 1'b1;
                fin_next = 1'b1;
                t_next   = (time_inc >= arr_rd_reg) ? time_inc - arr_rd_reg : '0;
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_run_next   = '0;
            out_idle_next  = 1'b0;
            out_seg_next   = 1'b0;
            out_fin_next   = 1'b0;
            out_tat_next   = '0;
            out_wt_next    = '0;
            out_done_next  = (unfin_reg == CNT_W'(fin_reg));
            out_time_next  = time_reg;
            if (item_tick_reg)
            begin
                if (found_reg)
                begin
                    out_run_next    = run_wide[SW-1:0];
                    out_seg_next    = !last_valid_reg || (last_job_reg != best_idx_reg);
                    out_fin_next    = fin_reg;
                    out_tat_next    = fin_reg ? t_reg : '0;
                    out_wt_next     = fin_reg ? w_val : '0;
                    last_job_next   = best_idx_reg;
                    last_valid_next = 1'b1;
                end
                else
                begin
                    // idle tick: advance time, drop the running job
                    out_idle_next   = 1'b1;
                    out_time_next   = time_inc;
                    time_next       = time_inc;
                    last_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg  <= pps_pkg::JOB_COUNT_RESET;
            time_reg       <= '0;
            last_job_reg   <= '0;
            last_valid_reg <= 1'b0;
            fin_flags_reg  <= '0;
            scan_cnt_reg   <= '0;
            p_valid_reg    <= 1'b0;
            unfin_reg      <= '0;
            found_reg      <= 1'b0;
            fin_reg        <= 1'b0;
            item_tick_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            job_count_reg  <= job_count_next;
            time_reg       <= time_next;
            last_job_reg   <= last_job_next;
            last_valid_reg <= last_valid_next;
            fin_flags_reg  <= fin_flags_next;
            scan_cnt_reg   <= scan_cnt_next;
            p_valid_reg    <= p_valid_next;
            unfin_reg      <= unfin_next;
            found_reg      <= found_next;
            fin_reg        <= fin_next;
            item_tick_reg  <= item_tick_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_slot_reg <= item_slot_next;
        item_arr_reg  <= item_arr_next;
        item_bur_reg  <= item_bur_next;
        item_pri_reg  <= item_pri_next;
        p_flag_reg    <= p_flag_next;
        p_idx_reg     <= p_idx_next;
        best_idx_reg  <= best_idx_next;
        best_pri_reg  <= best_pri_next;
        t_reg         <= t_next;
        out_run_reg   <= out_run_next;
        out_idle_reg  <= out_idle_next;
        out_seg_reg   <= out_seg_next;
        out_fin_reg   <= out_fin_next;
        out_tat_reg   <= out_tat_next;
        out_wt_reg    <= out_wt_next;
        out_done_reg  <= out_done_next;
        out_time_reg  <= out_time_next;
    end

    assign status.is_tick   = item_tick_reg;
    assign status.scan_done = (scan_cnt_reg == n_active) && !p_valid_reg;
    assign status.found     = found_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign running_index = out_run_reg;
    assign cpu_idle      = out_idle_reg;
    assign new_segment   = out_seg_reg;
    assign job_finished  = out_fin_reg;
    assign turnaround    = out_tat_reg;
    assign waiting       = out_wt_reg;
    assign all_done      = out_done_reg;
    assign time_now      = out_time_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result committed over an untaken result");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(cmd.commit))
        else $error("output valid rose without a commit");

    a_fin_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (found_reg && item_tick_reg))
        else $error("job finish flagged without a selected job");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg >= $past(time_reg))
        else $error("time went backward");

endmodule

// ----- rtl/core/preemptive_priority_scheduler_unit.sv -----
// Top level of the preemptive priority scheduler.
// Joins pps_ctrl and pps_datapath; depends on pps_pkg.
//
// Each item returns one result. The number of counted jobs is job_count,
// capped at MAX_JOBS. The tick walks the job table one entry per cycle
// through a single read port to find the ready job with the smallest
// priority value, then reads and writes back that job's entry. A load
// likewise walks the table to refresh the all_done status. One item is in
// flight at a time. A finished result waits in the output register while
// the next item can be accepted in the cycle after the commit. A result
// that finds the output register still occupied holds until it is taken.
// Table entries hold nothing until loaded, and every counted entry must be
// loaded before ticks are issued.
module preemptive_priority_scheduler_unit #(
    parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [pps_pkg::JOB_COUNT_W-1:0]   cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [pps_pkg::SLOT_IN_W-1:0]     entry_index,
    input  logic [pps_pkg::TIME_W-1:0]        entry_arrival,
    input  logic [pps_pkg::TIME_W-1:0]        entry_burst,
    input  logic [pps_pkg::PRI_W-1:0]         entry_priority,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pps_pkg::SLOT_IN_W-1:0]     running_index,
    output logic                              cpu_idle,
    output logic                              new_segment,
    output logic                              job_finished,
    output logic [pps_pkg::TIME_W-1:0]        turnaround,
    output logic [pps_pkg::TIME_W-1:0]        waiting,
    output logic                              all_done,
    output logic [pps_pkg::TIME_W-1:0]        time_now
);

    pps_pkg::pps_cmd_t    cmd;
    pps_pkg::pps_status_t status;

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .command        (command),
        .entry_index    (entry_index),
        .entry_arrival  (entry_arrival),
        .entry_burst    (entry_burst),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running_index  (running_index),
        .cpu_idle       (cpu_idle),
        .new_segment    (new_segment),
        .job_finished   (job_finished),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .all_done       (all_done),
        .time_now       (time_now)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for preemptive_priority_scheduler_unit: a table of load and tick
// items, then random job traffic, checked against a scheduler predictor in this file.
// Depends on pps_pkg and the scheduler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pps_pkg::*;

    localparam int SLOTS             = MAX_JOBS_DEF;
    localparam int PERIOD            = 20;
    localparam int QUIET_LIMIT       = 4000;
    localparam int ITEMS_PER_SETTING = 135;
    localparam int TAIL_ITEMS        = 150;
    localparam int HOLD_OFF_CYCLES   = 400;

    typedef struct packed {
        logic                 command;
        logic [SLOT_IN_W-1:0] index;
        logic [TIME_W-1:0]    arrival;
        logic [TIME_W-1:0]    burst;
        logic [PRI_W-1:0]     prio;
    } job_item_t;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] running_index;
        logic                 cpu_idle;
        logic                 new_segment;
        logic                 job_finished;
        logic [TIME_W-1:0]    turnaround;
        logic [TIME_W-1:0]    waiting;
        logic                 all_done;
        logic [TIME_W-1:0]    time_now;
    } sched_result_t;

    typedef struct {
        bit                     is_cfg;
        logic [JOB_COUNT_W-1:0] cfg_value;
        job_item_t              item;
        bit                     typed;
        sched_result_t          result;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [JOB_COUNT_W-1:0] cfg_write_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   command = CMD_LOAD;
    logic [SLOT_IN_W-1:0]   entry_index = '0;
    logic [TIME_W-1:0]      entry_arrival = '0;
    logic [TIME_W-1:0]      entry_burst = '0;
    logic [PRI_W-1:0]       entry_priority = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SLOT_IN_W-1:0]   running_index;
    logic                   cpu_idle;
    logic                   new_segment;
    logic                   job_finished;
    logic [TIME_W-1:0]      turnaround;
    logic [TIME_W-1:0]      waiting;
    logic                   all_done;
    logic [TIME_W-1:0]      time_now;

    // scheduler predictor state
    logic [TIME_W-1:0]      sched_arrival   [SLOTS];
    logic [TIME_W-1:0]      sched_burst     [SLOTS];
    logic [TIME_W-1:0]      sched_remaining [SLOTS];
    logic [PRI_W-1:0]       sched_prio      [SLOTS];
    bit                     sched_done      [SLOTS];
    logic [TIME_W-1:0]      sched_time = '0;
    logic [SLOT_IN_W-1:0]   sched_last = '0;
    bit                     sched_last_valid = 1'b0;
    logic [JOB_COUNT_W-1:0] sched_job_count = JOB_COUNT_RESET;

    bit                     slot_loaded [SLOTS];
    sched_result_t          expected_results [$];
    directed_row_t          directed_rows [$];
    int                     mismatch_count = 0;
    int                     quiet_cycles = 0;
    int                     tx_idle_pct = 34;
    int                     rx_idle_pct = 69;
    int                     rx_hold_request = 0;
    int                     rx_hold_left = 0;

    logic [JOB_COUNT_W-1:0] count_plan [12] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd9,
                                                5'd16, 5'd2, 5'd12, 5'd17, 5'd3, 5'd16};

    preemptive_priority_scheduler_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .entry_index    (entry_index),
        .entry_arrival  (entry_arrival),
        .entry_burst    (entry_burst),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .running_index  (running_index),
        .cpu_idle       (cpu_idle),
        .new_segment    (new_segment),
        .job_finished   (job_finished),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .all_done       (all_done),
        .time_now       (time_now)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic int counted_jobs();
        return (int'(sched_job_count) > SLOTS) ? SLOTS : int'(sched_job_count);
    endfunction

    function automatic sched_result_t schedule_step(job_item_t it);
        sched_result_t r;
        int            n;
        int            best;
        bit            found;
        int            span;
        int            finished;
        r = '0;
        n = counted_jobs();
        if (it.command == CMD_LOAD)
        begin
            sched_arrival[it.index]   = it.arrival;
            sched_burst[it.index]     = it.burst;
            sched_remaining[it.index] = it.burst;
            sched_prio[it.index]      = it.prio;
            sched_done[it.index]      = (it.burst == 0);
        end
        else
        begin
            best = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!sched_done[i] && sched_arrival[i] <= sched_time &&
                    (!found || sched_prio[i] < sched_prio[best]))
                begin
                    best = i;
                    found = 1'b1;
                end
            end
            if (sched_time != TIME_MAX)
                sched_time++;
            if (!found)
            begin
                r.cpu_idle = 1'b1;
                sched_last_valid = 1'b0;
            end
            else
            begin
                r.running_index = SLOT_IN_W'(best);
                r.new_segment = !sched_last_valid || sched_last != SLOT_IN_W'(best);
                sched_last = SLOT_IN_W'(best);
                sched_last_valid = 1'b1;
                if (sched_remaining[best] != 0)
                    sched_remaining[best]--;
                if (sched_remaining[best] == 0)
                begin
                    sched_done[best] = 1'b1;
                    r.job_finished = 1'b1;
                    span = (sched_time >= sched_arrival[best]) ?
                           int'(sched_time) - int'(sched_arrival[best]) : 0;
                    r.turnaround = TIME_W'(span);
                    // floor waiting at zero once time has saturated
                    r.waiting = (span >= int'(sched_burst[best])) ?
                                TIME_W'(span - int'(sched_burst[best])) : '0;
                end
            end
        end
        finished = 0;
        for (int i = 0; i < n; i++)
            if (sched_done[i])
                finished++;
        r.all_done = (finished == n);
        r.time_now = sched_time;
        return r;
    endfunction

    // Mostly well-formed jobs near the current time; some full-range noise.
    function automatic job_item_t next_job_item();
        job_item_t it;
        int        n;
        int        missing;
        int        start;
        it = '0;
        n = counted_jobs();
        missing = -1;
        for (int i = n - 1; i >= 0; i--)
            if (!slot_loaded[i])
                missing = i;
        if (missing < 0 && $urandom_range(0, 99) < 62)
        begin
            it.command = CMD_TICK;
            it.index = SLOT_IN_W'($urandom);
            return it;
        end
        it.command = CMD_LOAD;
        // fill a counted slot that was never loaded before any tick may run
        if (missing >= 0)
            it.index = SLOT_IN_W'(missing);
        else if (n == 0 || $urandom_range(0, 9) == 0)
            it.index = SLOT_IN_W'($urandom_range(0, SLOTS - 1));
        else
            it.index = SLOT_IN_W'($urandom_range(0, n - 1));
        if ($urandom_range(0, 99) < 12)
        begin
            it.arrival = TIME_W'($urandom);
            it.burst   = TIME_W'($urandom);
            it.prio    = PRI_W'($urandom);
        end
        else
        begin
            start = int'(sched_time) + int'($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0)
                start = int'($urandom_range(0, sched_time));
            it.arrival = (start > int'(TIME_MAX)) ? TIME_MAX : TIME_W'(start);
            it.burst = ($urandom_range(0, 9) == 0) ? '0 : TIME_W'($urandom_range(1, 6));
            it.prio = ($urandom_range(0, 4) == 0) ? PRI_W'($urandom) :
                      PRI_W'($urandom_range(0, 5));
        end
        return it;
    endfunction

    function automatic void row_load(int idx, int arr, int bur, int pri);
        directed_row_t row;
        row = '{default: '0};
        row.item = '{CMD_LOAD, SLOT_IN_W'(idx), TIME_W'(arr), TIME_W'(bur), PRI_W'(pri)};
        directed_rows.push_back(row);
    endfunction

    function automatic void row_tick();
        directed_row_t row;
        row = '{default: '0};
        row.item.command = CMD_TICK;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_cfg(int value);
        directed_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_value = JOB_COUNT_W'(value);
        directed_rows.push_back(row);
    endfunction

    function automatic void row_result(int run, bit idle, bit seg, bit fin, int tat,
                                       int wt, bit done, int tnow);
        int last;
        last = directed_rows.size() - 1;
        directed_rows[last].typed = 1'b1;
        directed_rows[last].result = {SLOT_IN_W'(run), idle, seg, fin, TIME_W'(tat),
                                      TIME_W'(wt), done, TIME_W'(tnow)};
    endfunction

    task automatic send_item(input job_item_t it, input bit typed,
                             input sched_result_t typed_res);
        sched_result_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid       <= 1'b1;
        command        <= it.command;
        entry_index    <= it.index;
        entry_arrival  <= it.arrival;
        entry_burst    <= it.burst;
        entry_priority <= it.prio;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = schedule_step(it);
        expected_results.push_back(typed ? typed_res : predicted);
        if (it.command == CMD_LOAD)
            slot_loaded[it.index] = 1'b1;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_job_count(input logic [JOB_COUNT_W-1:0] value);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sched_job_count = value;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (rx_hold_request != 0)
        begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        sched_result_t observed;
        sched_result_t wanted;
        if (rst_n && out_valid && out_ready)
        begin
            observed = {running_index, cpu_idle, new_segment, job_finished,
                        turnaround, waiting, all_done, time_now};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with nothing outstanding", $time);
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (observed !== wanted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: result mismatch", $time);
                        $write("  expected run %0d idle %0b seg %0b fin %0b",
                               wanted.running_index, wanted.cpu_idle,
                               wanted.new_segment, wanted.job_finished);
                        $display(" tat %0d wt %0d done %0b now %0d",
                                 wanted.turnaround, wanted.waiting,
                                 wanted.all_done, wanted.time_now);
                        $write("  actual   run %0d idle %0b seg %0b fin %0b",
                               observed.running_index, observed.cpu_idle,
                               observed.new_segment, observed.job_finished);
                        $display(" tat %0d wt %0d done %0b now %0d",
                                 observed.turnaround, observed.waiting,
                                 observed.all_done, observed.time_now);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        sched_result_t no_result;
        no_result = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sched_arrival[i] = '0;
            sched_burst[i] = '0;
            sched_remaining[i] = '0;
            sched_prio[i] = '0;
            sched_done[i] = 1'b0;
            slot_loaded[i] = 1'b0;
        end

        // job count starts at 1: slot 0 is the only counted entry
        row_load(0, 0, 2, 5);            row_result(0, 0, 0, 0, 0, 0, 0, 0);
        row_tick();                      row_result(0, 0, 1, 0, 0, 0, 0, 1);
        row_tick();                      row_result(0, 0, 0, 1, 2, 0, 1, 2);
        row_tick();                      row_result(0, 1, 0, 0, 0, 0, 1, 3);
        row_load(15, 65535, 65535, 255); row_result(0, 0, 0, 0, 0, 0, 1, 3);
        row_load(0, 0, 0, 0);            row_result(0, 0, 0, 0, 0, 0, 1, 3);
        row_cfg(2);
        row_load(1, 5, 3, 3);
        row_tick();
        row_load(0, 0, 4, 7);
        row_tick();
        // slot 1 arrives and preempts slot 0
        row_tick();
        row_tick();
        row_tick();
        row_tick();
        // equal priorities: lower index wins
        row_load(1, 0, 1, 7);
        row_tick();
        row_tick();
        row_tick();
        row_tick();
        row_cfg(0);
        row_tick();
        row_load(7, 12, 1, 0);
        row_tick();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
                write_job_count(directed_rows[r].cfg_value);
            else
                send_item(directed_rows[r].item, directed_rows[r].typed,
                          directed_rows[r].result);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 69 : 0;
            rx_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 34 : 0;
            for (int s = 0; s < 4; s++)
            begin
                write_job_count(count_plan[phase * 4 + s]);
                for (int k = 0; k < ITEMS_PER_SETTING; k++)
                begin
                    if (k == ITEMS_PER_SETTING / 2 && phase == 0 && s == 1)
                        rx_hold_request = HOLD_OFF_CYCLES;
                    if (k == ITEMS_PER_SETTING / 2 && phase == 1 && s == 2)
                        drain_results();
                    send_item(next_job_item(), 1'b0, no_result);
                end
            end
        end

        // finish with a short run over six counted slots
        write_job_count(5'd6);
        for (int k = 0; k < TAIL_ITEMS; k++)
            send_item(next_job_item(), 1'b0, no_result);

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_ctrl.sv
rtl/core/pps_datapath.sv
rtl/core/preemptive_priority_scheduler_unit.sv
sim/tb.sv
